>>> hdl/window_and_layer_priority_mux_top_macros.svh
// Assertion macros for the window and layer priority multiplexer.
// Taken in by the checker file; depends on nothing else.
`ifndef WINDOW_AND_LAYER_PRIORITY_MUX_TOP_MACROS_SVH
`define WINDOW_AND_LAYER_PRIORITY_MUX_TOP_MACROS_SVH

// A property checked at every rising edge outside reset.
`define WLPM_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property checked at every rising edge, reset included.
`define WLPM_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/wlpm_pkg.sv
// Shared types and constants of the window and layer priority multiplexer.
// Used by every RTL module and by the checker; depends on nothing.
package wlpm_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [2:0] REG_WINDOW_FROM_RIGHT   = 3'd0;
  localparam logic [2:0] REG_WINDOW_COL_LIMIT    = 3'd1;
  localparam logic [2:0] REG_WINDOW_FROM_BOTTOM  = 3'd2;
  localparam logic [2:0] REG_WINDOW_ROW_LIMIT    = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH_TILES  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT_TILES = 3'd5;
  localparam logic [2:0] REG_BACKDROP_PALETTE    = 3'd6;
  localparam logic [2:0] REG_BACKDROP_ENTRY      = 3'd7;

  localparam logic [5:0] SCREEN_WIDTH_RESET  = 6'd40;
  localparam logic [4:0] SCREEN_HEIGHT_RESET = 5'd28;

  localparam logic [2:0] LAYER_BACKDROP = 3'd0;
  localparam logic [2:0] LAYER_PLANE_A  = 3'd1;
  localparam logic [2:0] LAYER_PLANE_B  = 3'd2;
  localparam logic [2:0] LAYER_SPRITE   = 3'd3;
  localparam logic [2:0] LAYER_WINDOW   = 3'd4;

  typedef struct packed {
    logic       window_from_right;
    logic [4:0] window_col_limit;
    logic       window_from_bottom;
    logic [4:0] window_row_limit;
    logic [5:0] screen_width_tiles;
    logic [4:0] screen_height_tiles;
    logic [1:0] backdrop_palette;
    logic [3:0] backdrop_entry;
  } cfg_t;

endpackage

>>> hdl/wlpm_regs.sv
// Configuration register file of the window and layer priority multiplexer,
// written and read over the APB-style port. Depends on wlpm_pkg.
module wlpm_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wlpm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [wlpm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [wlpm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output wlpm_pkg::cfg_t                   cfg
);

  logic [2:0] reg_index;
  logic       write_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign write_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_from_right   <= 1'b0;
      cfg.window_col_limit    <= 5'd0;
      cfg.window_from_bottom  <= 1'b0;
      cfg.window_row_limit    <= 5'd0;
      cfg.screen_width_tiles  <= wlpm_pkg::SCREEN_WIDTH_RESET;
      cfg.screen_height_tiles <= wlpm_pkg::SCREEN_HEIGHT_RESET;
      cfg.backdrop_palette    <= 2'd0;
      cfg.backdrop_entry      <= 4'd0;
    end else if (write_en) begin
      case (reg_index)
        wlpm_pkg::REG_WINDOW_FROM_RIGHT:   cfg.window_from_right   <= pwdata[0];
        wlpm_pkg::REG_WINDOW_COL_LIMIT:    cfg.window_col_limit    <= pwdata[4:0];
        wlpm_pkg::REG_WINDOW_FROM_BOTTOM:  cfg.window_from_bottom  <= pwdata[0];
        wlpm_pkg::REG_WINDOW_ROW_LIMIT:    cfg.window_row_limit    <= pwdata[4:0];
        wlpm_pkg::REG_SCREEN_WIDTH_TILES:  cfg.screen_width_tiles  <= pwdata[5:0];
        wlpm_pkg::REG_SCREEN_HEIGHT_TILES: cfg.screen_height_tiles <= pwdata[4:0];
        wlpm_pkg::REG_BACKDROP_PALETTE:    cfg.backdrop_palette    <= pwdata[1:0];
        wlpm_pkg::REG_BACKDROP_ENTRY:      cfg.backdrop_entry      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_index)
      wlpm_pkg::REG_WINDOW_FROM_RIGHT:   prdata[0]   = cfg.window_from_right;
      wlpm_pkg::REG_WINDOW_COL_LIMIT:    prdata[4:0] = cfg.window_col_limit;
      wlpm_pkg::REG_WINDOW_FROM_BOTTOM:  prdata[0]   = cfg.window_from_bottom;
      wlpm_pkg::REG_WINDOW_ROW_LIMIT:    prdata[4:0] = cfg.window_row_limit;
      wlpm_pkg::REG_SCREEN_WIDTH_TILES:  prdata[5:0] = cfg.screen_width_tiles;
      wlpm_pkg::REG_SCREEN_HEIGHT_TILES: prdata[4:0] = cfg.screen_height_tiles;
      wlpm_pkg::REG_BACKDROP_PALETTE:    prdata[1:0] = cfg.backdrop_palette;
      wlpm_pkg::REG_BACKDROP_ENTRY:      prdata[3:0] = cfg.backdrop_entry;
      default: prdata = '0;
    endcase
  end

endmodule

>>> hdl/wlpm_window.sv
// Window region test: decides whether the window covers a pixel from its
// tile column and row and the window registers. Depends on wlpm_pkg.
module wlpm_window (
  input  logic [8:0]     pixel_x,
  input  logic [7:0]     scan_line,
  input  wlpm_pkg::cfg_t cfg,
  output logic           covered
);

  logic [5:0] col;
  logic [4:0] row;
  logic [5:0] limit_cols;
  logic [5:0] col_start;
  logic [5:0] col_end_raw;
  logic [5:0] col_end;
  logic [4:0] row_start;
  logic [4:0] row_end;

  assign col        = pixel_x[8:3];
  assign row        = scan_line[7:3];
  assign limit_cols = {cfg.window_col_limit, 1'b0};

  always_comb begin
    col_start   = cfg.window_from_right ? limit_cols : 6'd0;
    col_end_raw = (cfg.window_from_right || (cfg.window_col_limit == 5'd0))
                  ? cfg.screen_width_tiles : limit_cols;
    col_end     = (col_end_raw > cfg.screen_width_tiles) ? cfg.screen_width_tiles
                                                         : col_end_raw;
    row_start   = cfg.window_from_bottom ? cfg.window_row_limit : 5'd0;
    row_end     = cfg.window_from_bottom ? cfg.screen_height_tiles : cfg.window_row_limit;
    covered     = (row >= row_start) && (row < row_end) &&
                  (col >= col_start) && (col < col_end);
  end

endmodule

>>> hdl/wlpm_select.sv
// Layer priority resolution between sprite, plane A (or window) and plane B,
// with colour 0 transparent and the backdrop behind all. Depends on wlpm_pkg.
module wlpm_select (
  input  logic [6:0]     plane_a_pixel,
  input  logic [6:0]     plane_b_pixel,
  input  logic [5:0]     window_pixel,
  input  logic [6:0]     sprite_pixel,
  input  logic           covered,
  input  wlpm_pkg::cfg_t cfg,
  output logic [5:0]     color_ram_index,
  output logic [2:0]     source_layer
);

  logic [6:0] a;
  logic [2:0] a_layer;
  logic       a_clear;
  logic       b_clear;
  logic       s_clear;
  logic       a_high;
  logic       b_high;
  logic       s_high;

  always_comb begin
    a       = covered ? {1'b1, window_pixel} : plane_a_pixel;
    a_layer = covered ? wlpm_pkg::LAYER_WINDOW : wlpm_pkg::LAYER_PLANE_A;
    a_clear = (a[3:0] == 4'd0);
    b_clear = (plane_b_pixel[3:0] == 4'd0);
    s_clear = (sprite_pixel[3:0] == 4'd0);
    a_high  = a[6];
    b_high  = plane_b_pixel[6];
    s_high  = sprite_pixel[6];

    if (s_clear) begin
      if (a_clear) begin
        if (b_clear) begin
          color_ram_index = {cfg.backdrop_palette, cfg.backdrop_entry};
          source_layer    = wlpm_pkg::LAYER_BACKDROP;
        end else begin
          color_ram_index = plane_b_pixel[5:0];
          source_layer    = wlpm_pkg::LAYER_PLANE_B;
        end
      end else if (a_high) begin
        color_ram_index = a[5:0];
        source_layer    = a_layer;
      end else if (b_high && !b_clear) begin
        color_ram_index = plane_b_pixel[5:0];
        source_layer    = wlpm_pkg::LAYER_PLANE_B;
      end else begin
        color_ram_index = a[5:0];
        source_layer    = a_layer;
      end
    end else if (s_high) begin
      color_ram_index = sprite_pixel[5:0];
      source_layer    = wlpm_pkg::LAYER_SPRITE;
    end else if (a_high && !a_clear) begin
      color_ram_index = a[5:0];
      source_layer    = a_layer;
    end else if (b_high && !b_clear) begin
      color_ram_index = plane_b_pixel[5:0];
      source_layer    = wlpm_pkg::LAYER_PLANE_B;
    end else begin
      color_ram_index = sprite_pixel[5:0];
      source_layer    = wlpm_pkg::LAYER_SPRITE;
    end
  end

endmodule

>>> hdl/window_and_layer_priority_mux_top.sv
// Top level of the window and layer priority multiplexer: input register,
// window test, priority select and result register. Depends on wlpm_pkg,
// wlpm_regs, wlpm_window and wlpm_select.
//
// Pixel items arrive on the s_axis channel and the chosen colour RAM index
// leaves on the m_axis channel, with the layer it came from in m_axis_tuser.
// The user is to set registers over the APB-style port while no item is in
// flight; the block does not enforce this. An accepted item is registered,
// resolved by the window test and priority select, and offered on m_axis from
// the result register. One item is taken per cycle unless the receiver stalls;
// the rate is set by one register stage on each side of the select logic.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; only then is s_axis_tready lowered.
// Reset empties both stages and returns the registers to their reset values
// (screen width 40 tiles, height 28 rows, everything else zero).
module window_and_layer_priority_mux_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wlpm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [wlpm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [wlpm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_x, scan_line, plane_a_pixel, plane_b_pixel, window_pixel, sprite_pixel
  input  logic [47:0]                      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // color_ram_index
  output logic [7:0]                       m_axis_tdata,
  // source_layer
  output logic [2:0]                       m_axis_tuser
);

  wlpm_pkg::cfg_t cfg;

  logic       stage_valid;
  logic [8:0] pixel_x;
  logic [7:0] scan_line;
  logic [6:0] plane_a_pixel;
  logic [6:0] plane_b_pixel;
  logic [5:0] window_pixel;
  logic [6:0] sprite_pixel;

  logic       covered;
  logic [5:0] color_ram_index_next;
  logic [2:0] source_layer_next;

  logic       out_valid;
  logic [5:0] color_ram_index;
  logic [2:0] source_layer;

  logic       out_free;
  logic       stage_advance;

  assign out_free      = !out_valid || m_axis_tready;
  assign stage_advance = stage_valid && out_free;
  assign s_axis_tready = !stage_valid || stage_advance;

  wlpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pixel_x       <= s_axis_tdata[8:0];
      scan_line     <= s_axis_tdata[16:9];
      plane_a_pixel <= s_axis_tdata[23:17];
      plane_b_pixel <= s_axis_tdata[30:24];
      window_pixel  <= s_axis_tdata[36:31];
      sprite_pixel  <= s_axis_tdata[43:37];
    end
  end

  wlpm_window u_window (
    .pixel_x   (pixel_x),
    .scan_line (scan_line),
    .cfg       (cfg),
    .covered   (covered)
  );

  wlpm_select u_select (
    .plane_a_pixel   (plane_a_pixel),
    .plane_b_pixel   (plane_b_pixel),
    .window_pixel    (window_pixel),
    .sprite_pixel    (sprite_pixel),
    .covered         (covered),
    .cfg             (cfg),
    .color_ram_index (color_ram_index_next),
    .source_layer    (source_layer_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      color_ram_index <= color_ram_index_next;
      source_layer    <= source_layer_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, color_ram_index};
  assign m_axis_tuser  = source_layer;

endmodule

>>> hdl/wlpm_checker.sv
// Port-level checker for the window and layer priority multiplexer and the
// bind that attaches it. Depends on the assertion macro header.
`include "window_and_layer_priority_mux_top_macros.svh"

module wlpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser
);

  `WLPM_ASSERT_RST(a_reset_empties, clk, rst |=> !m_axis_tvalid, "result offered after reset")

  `WLPM_ASSERT(a_result_two_cycles, clk, rst,
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid,
    "accepted item not offered two cycles later")

  `WLPM_ASSERT(a_stall_holds, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled result changed")

  `WLPM_ASSERT(a_ready_when_empty, clk, rst,
    !m_axis_tvalid |-> s_axis_tready,
    "input refused with the result register empty")

endmodule

bind window_and_layer_priority_mux_top wlpm_checker u_checker (.*);

>>> tb/window_and_layer_priority_mux_checker.sv
// Checker for the window and layer priority multiplexer: follows register writes on the
// APB port, predicts each pixel result and compares it with what leaves m_axis.
// Depends on wlpm_pkg for the register indexes, layer codes and the settings struct.
module window_and_layer_priority_mux_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          mismatch_count,
  output int          pending,
  output int          checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0] color_index;
    logic [2:0] layer;
  } pixel_result_t;

  wlpm_pkg::cfg_t shadow_cfg;
  pixel_result_t  expected_pixels[$];

  function automatic logic is_clear(input logic [6:0] p);
    return p[3:0] == 4'd0;
  endfunction

  function automatic logic window_hit(input logic [8:0] x, input logic [7:0] line,
                                      input wlpm_pkg::cfg_t c);
    int col, row, c0, c1, r0, r1;
    col = int'(x) / 8;
    row = int'(line) / 8;
    c0 = c.window_from_right ? 2 * int'(c.window_col_limit) : 0;
    c1 = c.window_from_right ? int'(c.screen_width_tiles) : 2 * int'(c.window_col_limit);
    if (!c.window_from_right && c.window_col_limit == 5'd0) c1 = int'(c.screen_width_tiles);
    if (c1 > int'(c.screen_width_tiles)) c1 = int'(c.screen_width_tiles);
    r0 = c.window_from_bottom ? int'(c.window_row_limit) : 0;
    r1 = c.window_from_bottom ? int'(c.screen_height_tiles) : int'(c.window_row_limit);
    return row >= r0 && row < r1 && col >= c0 && col < c1;
  endfunction

  function automatic pixel_result_t resolve_pixel(input logic [47:0] d,
                                                  input wlpm_pkg::cfg_t c);
    logic [6:0]    a, b, s;
    logic [2:0]    a_src;
    pixel_result_t r;
    a = d[23:17];
    b = d[30:24];
    s = d[43:37];
    a_src = wlpm_pkg::LAYER_PLANE_A;
    if (window_hit(d[8:0], d[16:9], c)) begin
      a = {1'b1, d[36:31]};
      a_src = wlpm_pkg::LAYER_WINDOW;
    end
    if (is_clear(s)) begin
      if (is_clear(a)) begin
        if (is_clear(b)) r = '{{c.backdrop_palette, c.backdrop_entry}, wlpm_pkg::LAYER_BACKDROP};
        else r = '{b[5:0], wlpm_pkg::LAYER_PLANE_B};
      end else if (a[6]) begin
        r = '{a[5:0], a_src};
      end else if (b[6] && !is_clear(b)) begin
        r = '{b[5:0], wlpm_pkg::LAYER_PLANE_B};
      end else begin
        r = '{a[5:0], a_src};
      end
    end else if (s[6]) begin
      r = '{s[5:0], wlpm_pkg::LAYER_SPRITE};
    end else if (a[6] && !is_clear(a)) begin
      r = '{a[5:0], a_src};
    end else if (b[6] && !is_clear(b)) begin
      r = '{b[5:0], wlpm_pkg::LAYER_PLANE_B};
    end else begin
      r = '{s[5:0], wlpm_pkg::LAYER_SPRITE};
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      shadow_cfg <= '{1'b0, 5'd0, 1'b0, 5'd0, wlpm_pkg::SCREEN_WIDTH_RESET,
                      wlpm_pkg::SCREEN_HEIGHT_RESET, 2'd0, 4'd0};
      expected_pixels.delete();
      mismatch_count <= 0;
      pending <= 0;
      checked_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          wlpm_pkg::REG_WINDOW_FROM_RIGHT:   shadow_cfg.window_from_right <= pwdata[0];
          wlpm_pkg::REG_WINDOW_COL_LIMIT:    shadow_cfg.window_col_limit <= pwdata[4:0];
          wlpm_pkg::REG_WINDOW_FROM_BOTTOM:  shadow_cfg.window_from_bottom <= pwdata[0];
          wlpm_pkg::REG_WINDOW_ROW_LIMIT:    shadow_cfg.window_row_limit <= pwdata[4:0];
          wlpm_pkg::REG_SCREEN_WIDTH_TILES:  shadow_cfg.screen_width_tiles <= pwdata[5:0];
          wlpm_pkg::REG_SCREEN_HEIGHT_TILES: shadow_cfg.screen_height_tiles <= pwdata[4:0];
          wlpm_pkg::REG_BACKDROP_PALETTE:    shadow_cfg.backdrop_palette <= pwdata[1:0];
          wlpm_pkg::REG_BACKDROP_ENTRY:      shadow_cfg.backdrop_entry <= pwdata[3:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        checked_count <= checked_count + 1;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected item, index %0d layer %0d", $time,
                   m_axis_tdata, m_axis_tuser);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata != {2'b00, want.color_index} || m_axis_tuser != want.layer) begin
            $display("%0t: mismatch, expected index %0d layer %0d, got index %0d layer %0d",
                     $time, want.color_index, want.layer, m_axis_tdata, m_axis_tuser);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_pixels.push_back(resolve_pixel(s_axis_tdata, shadow_cfg));
      pending <= expected_pixels.size();
    end
  end

endmodule

>>> tb/window_and_layer_priority_mux_top_tb.sv
// Top of the testbench for the window and layer priority multiplexer: clock, reset,
// register settings, pixel stimulus with idling patterns, watchdog and verdict.
// Depends on wlpm_pkg, the block and window_and_layer_priority_mux_checker.
module window_and_layer_priority_mux_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int RANDOM_PER_PHASE = 81;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int mismatch_count, pending, checked_count;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int settings_applied = 0;

  window_and_layer_priority_mux_top dut (.*);

  window_and_layer_priority_mux_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  function automatic logic [47:0] make_pixel(input logic [8:0] x, input logic [7:0] line,
                                             input logic [6:0] a, input logic [6:0] b,
                                             input logic [5:0] w, input logic [6:0] s);
    return {4'b0000, s, w, b, a, line, x};
  endfunction

  function automatic logic [6:0] rand_layer_pixel();
    int pick;
    logic [6:0] p;
    pick = $urandom_range(9);
    p[6:4] = 3'($urandom_range(7));
    p[3:0] = (pick < 5) ? 4'd0 : 4'($urandom_range(15, 1));
    if (pick < 2) p = 7'($urandom_range(127));
    return p;
  endfunction

  function automatic logic [5:0] rand_window_pixel();
    logic [5:0] w;
    w = 6'($urandom_range(63));
    if ($urandom_range(3) == 0) w[3:0] = 4'd0;
    return w;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_settings(input wlpm_pkg::cfg_t c);
    apb_write(wlpm_pkg::REG_WINDOW_FROM_RIGHT, 32'(c.window_from_right));
    apb_write(wlpm_pkg::REG_WINDOW_COL_LIMIT, 32'(c.window_col_limit));
    apb_write(wlpm_pkg::REG_WINDOW_FROM_BOTTOM, 32'(c.window_from_bottom));
    apb_write(wlpm_pkg::REG_WINDOW_ROW_LIMIT, 32'(c.window_row_limit));
    apb_write(wlpm_pkg::REG_SCREEN_WIDTH_TILES, 32'(c.screen_width_tiles));
    apb_write(wlpm_pkg::REG_SCREEN_HEIGHT_TILES, 32'(c.screen_height_tiles));
    apb_write(wlpm_pkg::REG_BACKDROP_PALETTE, 32'(c.backdrop_palette));
    apb_write(wlpm_pkg::REG_BACKDROP_ENTRY, 32'(c.backdrop_entry));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  task automatic send_pixel(input logic [47:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic wait_drained(input int extra);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    wlpm_pkg::cfg_t settings[PHASES];
    settings[0] = '{1'b0, 5'd0, 1'b0, 5'd10, 6'd40, 5'd28, 2'd2, 4'd9};
    settings[1] = '{1'b0, 5'd0, 1'b0, 5'd0, 6'd40, 5'd28, 2'd0, 4'd0};
    settings[2] = '{1'b1, 5'd31, 1'b1, 5'd31, 6'd32, 5'd30, 2'd3, 4'd15};
    settings[3] = '{1'b0, 5'd31, 1'b0, 5'd31, 6'd32, 5'd28, 2'd1, 4'd6};
    settings[4] = '{1'b1, 5'd5, 1'b1, 5'd14, 6'd40, 5'd30, 2'd3, 4'd0};
    settings[5] = '{1'b0, 5'd10, 1'b0, 5'd20, 6'd36, 5'd29, 2'd0, 4'd15};
    for (int i = 6; i < PHASES; i++) begin
      settings[i] = '{1'($urandom_range(1)), 5'($urandom_range(31)), 1'($urandom_range(1)),
                      5'($urandom_range(31)), 6'($urandom_range(40, 32)),
                      5'($urandom_range(30, 28)), 2'($urandom_range(3)),
                      4'($urandom_range(15))};
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_settings(settings[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      if (ph == 0) begin
        // Rows 0 to 9 are covered across the full width here.
        send_pixel(make_pixel(9'd0, 8'd0, 7'h00, 7'h00, 6'h00, 7'h00));
        send_pixel(make_pixel(9'd319, 8'd239, 7'h00, 7'h00, 6'h00, 7'h00));
        send_pixel(make_pixel(9'd319, 8'd239, 7'h7F, 7'h7F, 6'h3F, 7'h7F));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h05, 7'h4A, 6'h00, 7'h00));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h45, 7'h4A, 6'h00, 7'h00));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h15, 7'h0A, 6'h00, 7'h00));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h00, 7'h2C, 6'h00, 7'h00));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h40, 7'h4C, 6'h00, 7'h00));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h45, 7'h00, 6'h00, 7'h33));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h05, 7'h4A, 6'h00, 7'h33));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h05, 7'h0A, 6'h00, 7'h33));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h40, 7'h40, 6'h00, 7'h33));
        send_pixel(make_pixel(9'd100, 8'd200, 7'h15, 7'h00, 6'h00, 7'h70));
        send_pixel(make_pixel(9'd8, 8'd79, 7'h7F, 7'h4F, 6'h00, 7'h00));
        send_pixel(make_pixel(9'd8, 8'd79, 7'h05, 7'h00, 6'h3F, 7'h33));
        send_pixel(make_pixel(9'd8, 8'd80, 7'h25, 7'h00, 6'h3F, 7'h00));
        send_pixel(make_pixel(9'd312, 8'd0, 7'h00, 7'h00, 6'h21, 7'h51));
        send_pixel(make_pixel(9'd255, 8'd40, 7'h00, 7'h4F, 6'h1E, 7'h00));
        send_pixel(make_pixel(9'd0, 8'd239, 7'h7F, 7'h7F, 6'h3F, 7'h0F));
        send_pixel(make_pixel(9'd256, 8'd128, 7'h00, 7'h00, 6'h00, 7'h0F));
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_pixel(make_pixel(9'($urandom_range(319)), 8'($urandom_range(239)),
                              rand_layer_pixel(), rand_layer_pixel(), rand_window_pixel(),
                              rand_layer_pixel()));
      end
      s_axis_tvalid <= 1'b0;
      wait_drained(4);
    end
    wait_drained(16);

    $display("tb: %0d pixel items checked (%0d results) over %0d register settings,",
             items_sent, checked_count, settings_applied);
    $display("tb: with free-running, sender-idle, receiver-stall and mixed handshakes");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
